// ===== design/bmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared widths, controller states and command/status types for the
// box minimum distance core.
// ----------------------------------------------------------------------------
package bmd_pkg;

  // Coordinate and result widths
  localparam int COORD_BITS = 16;
  localparam int GAP_BITS   = COORD_BITS;        // positive gap magnitude
  localparam int SQ_BITS    = 2 * GAP_BITS;      // squared gap
  localparam int SUM_BITS   = 36;                // saturating sum of squares
  localparam int DIST_BITS  = SUM_BITS / 2;      // floor square root
  localparam int ROOT_TOP   = SUM_BITS - 2;      // highest power of four below 2^SUM_BITS

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_BITS  = 4 * COORD_BITS;
  localparam int OUT_DATA_BITS = ((DIST_BITS + 7) / 8) * 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_HOLD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // register gap of the accepted item
    logic square;      // register squared gap
    logic accum;       // add squared gap into the sum
    logic root_start;  // load root unit from the updated sum, clear the sum
    logic root_step;   // one root iteration
    logic load_out;    // move finished root into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;        // captured item closes the box pair
    logic root_done;   // current root iteration is the final one
  } stat_t;

endpackage

// ===== design/bmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmd_ctrl
// Controller: sequences capture, squaring, accumulation, the square root
// iterations and the output handoff.
// ----------------------------------------------------------------------------
module bmd_ctrl
  import bmd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;
  logic   acc_pend;
  logic   acc_pend_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // State register and pending accumulate flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc_pend <= 1'b0;
    end else begin
      state    <= state_next;
      acc_pend <= acc_pend_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SQUARE;
      ST_SQUARE: state_next = stat.last ? ST_ACCUM : ST_IDLE;
      ST_ACCUM:  state_next = ST_ROOT;
      ST_ROOT:   if (stat.root_done) state_next = ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Non-last items accumulate in the following idle cycle
  always_comb begin
    acc_pend_next = 1'b0;
    if (state == ST_SQUARE && !stat.last) begin
      acc_pend_next = 1'b1;
    end
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        cmd.accum   = acc_pend;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
      end
      ST_ACCUM: begin
        cmd.accum      = 1'b1;
        cmd.root_start = 1'b1;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output item valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/bmd_datapath.sv =====
// ----------------------------------------------------------------------------
// bmd_datapath
// Datapath: per-dimension gap, registered square, saturating sum of squares,
// bit-per-cycle floor square root and the output register.
// ----------------------------------------------------------------------------
module bmd_datapath
  import bmd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [COORD_BITS-1:0] box_a_low,
  input  logic signed [COORD_BITS-1:0] box_a_high,
  input  logic signed [COORD_BITS-1:0] box_b_low,
  input  logic signed [COORD_BITS-1:0] box_b_high,
  input  logic                        last_dim,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  output logic [DIST_BITS-1:0]        distance
);

  logic signed [COORD_BITS-1:0] lo_max;
  logic signed [COORD_BITS-1:0] hi_min;
  logic signed [COORD_BITS:0]   gap;
  logic [GAP_BITS-1:0]          gap_mag;
  logic                         last;
  logic [SQ_BITS-1:0]           sq;
  logic [SUM_BITS-1:0]          sum;
  logic [SUM_BITS:0]            sum_wide;
  logic [SUM_BITS-1:0]          sum_next;
  logic [SUM_BITS-1:0]          rem;
  logic [SUM_BITS-1:0]          root;
  logic [SUM_BITS-1:0]          bit_pos;
  logic [SUM_BITS:0]            trial;
  logic                         fits;

  // Gap of this dimension: larger low corner minus smaller high corner
  assign lo_max = (box_a_low  > box_b_low)  ? box_a_low  : box_b_low;
  assign hi_min = (box_a_high < box_b_high) ? box_a_high : box_b_high;
  assign gap    = {lo_max[COORD_BITS-1], lo_max} - {hi_min[COORD_BITS-1], hi_min};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gap_mag <= (gap > 0) ? gap[GAP_BITS-1:0] : '0;
      last    <= last_dim;
    end
  end

  // Square stage
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= gap_mag * gap_mag;
    end
  end

  // Saturating sum of squares
  assign sum_wide = {1'b0, sum} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, sq};
  assign sum_next = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.root_start) begin
      sum <= '0;
    end else if (cmd.accum) begin
      sum <= sum_next;
    end
  end

  // Floor square root, one result bit per cycle
  assign trial = {1'b0, root} + {1'b0, bit_pos};
  assign fits  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rem     <= sum_next;
      root    <= '0;
      bit_pos <= SUM_BITS'(1) << ROOT_TOP;
    end else if (cmd.root_step) begin
      if (fits) begin
        rem  <= rem - trial[SUM_BITS-1:0];
        root <= (root >> 1) + bit_pos;
      end else begin
        root <= root >> 1;
      end
      bit_pos <= bit_pos >> 2;
    end
  end

  assign stat.last      = last;
  assign stat.root_done = bit_pos[0];

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      distance <= root[DIST_BITS-1:0];
    end
  end

endmodule

// ===== design/box_min_distance_core.sv =====
// ----------------------------------------------------------------------------
// box_min_distance_core
// Minimum Euclidean distance between two axis-aligned boxes, one dimension
// per input item, floor square root of the summed squared gaps out.
// ----------------------------------------------------------------------------
// Each input item carries one dimension of both boxes (signed Q8.8 corners);
// s_tlast marks the final dimension of a box pair. A dimension that is not
// the last passes through capture and square (its accumulate overlaps the
// next capture). The last dimension of a pair adds square, accumulate, 18
// square root iterations from the one-bit-per-cycle root unit and an output
// load, and s_tready returns only after that load, which waits until the
// output register is free. The result (unsigned Q10.8) waits in an output
// register, so the next pair may stream in while it is still unclaimed; the
// sum of squares saturates at 2^36-1 and is cleared once each result is
// formed.
module box_min_distance_core
  import bmd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [15:0] box_a_low, [31:16] box_a_high, [47:32] box_b_low, [63:48] box_b_high
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [17:0] distance, [23:18] zero
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  cmd_t                 cmd;
  stat_t                stat;
  logic [DIST_BITS-1:0] distance;

  bmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .box_a_low  (s_tdata[COORD_BITS-1:0]),
    .box_a_high (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .box_b_low  (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .box_b_high (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .last_dim   (s_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .distance   (distance)
  );

  assign m_tdata = {{(OUT_DATA_BITS - DIST_BITS){1'b0}}, distance};

`ifndef SYNTHESIS
  // An accepted item keeps the block busy for at least the square cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted item");

  // The root unit only starts on the closing dimension of a pair
  a_root_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |-> stat.last)
    else $error("square root started without a last item");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register loaded over an unclaimed result");
`endif

endmodule

// ===== tb/tb_box_min_distance_core.sv =====
// ----------------------------------------------------------------------------
// tb_box_min_distance_core
// Self-checking bench for the box minimum distance core: box corners stream
// in one dimension per item, and each distance is checked against a local
// model of the gap, saturating sum of squares and floor square root.
// ----------------------------------------------------------------------------
module tb_box_min_distance_core
  import bmd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One dimension of both boxes, box_a_low in the lowest bits
  typedef struct packed {
    logic signed [COORD_BITS-1:0] b_hi;
    logic signed [COORD_BITS-1:0] b_lo;
    logic signed [COORD_BITS-1:0] a_hi;
    logic signed [COORD_BITS-1:0] a_lo;
  } dim_t;

  localparam logic [SUM_BITS-1:0] SUM_SAT = '1;
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;
  logic                     s_tlast;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  // Model state and expected distances
  logic [SUM_BITS-1:0]  sum_sq_acc;
  logic [DIST_BITS-1:0] dist_q[$];
  int                   err_count;

  // Idling controls and receiver hold-off request
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_req;

  box_min_distance_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root, one result bit per pass from the top
  function automatic logic [DIST_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] v);
    logic [DIST_BITS-1:0] r;
    logic [DIST_BITS-1:0] c;
    r = '0;
    for (int b = DIST_BITS - 1; b >= 0; b--) begin
      c = r | (DIST_BITS'(1) << b);
      if (64'(c) * 64'(c) <= 64'(v)) r = c;
    end
    return r;
  endfunction

  // Gap of one dimension folded into the sum; a closing item yields a distance
  task automatic absorb_dim(input dim_t d, input logic last);
    int                  lo;
    int                  hi;
    int                  gap;
    logic [SUM_BITS-1:0] sq;
    lo = (d.a_lo > d.b_lo) ? d.a_lo : d.b_lo;
    hi = (d.a_hi < d.b_hi) ? d.a_hi : d.b_hi;
    gap = lo - hi;
    if (gap > 0) begin
      sq = SUM_BITS'(longint'(gap) * longint'(gap));
      if (sq > SUM_SAT - sum_sq_acc) sum_sq_acc = SUM_SAT;
      else sum_sq_acc = sum_sq_acc + sq;
    end
    if (last) begin
      dist_q.push_back(floor_root(sum_sq_acc));
      sum_sq_acc = '0;
    end
  endtask

  function automatic dim_t mk_dim(input logic signed [COORD_BITS-1:0] al, ah, bl, bh);
    dim_t d;
    d.a_lo = al;
    d.a_hi = ah;
    d.b_lo = bl;
    d.b_hi = bh;
    return d;
  endfunction

  // Offer one item, wait for the handshake, then maybe idle
  task automatic send_dim(input dim_t d, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    absorb_dim(d, last);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Sender stops and waits for every expected distance
  task automatic wait_results_done();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (dist_q.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (dist_q.size() != 0) begin
      $display("%0t: %0d distances never arrived, next expected %0d",
               $time, dist_q.size(), dist_q[0]);
      err_count += dist_q.size();
      dist_q.delete();
    end
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3:    return COORD_BITS'($urandom_range(0, 2047)) - COORD_BITS'(1024);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Random box pair dimension; mostly ordered corners, some inverted
  function automatic dim_t rand_dim();
    dim_t                         d;
    logic signed [COORD_BITS-1:0] t;
    d = mk_dim(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    if ($urandom_range(0, 3) != 0) begin
      if (d.a_lo > d.a_hi) begin
        t = d.a_lo; d.a_lo = d.a_hi; d.a_hi = t;
      end
      if (d.b_lo > d.b_hi) begin
        t = d.b_lo; d.b_lo = d.b_hi; d.b_hi = t;
      end
    end
    return d;
  endfunction

  // Random box pairs until at least n items are sent
  task automatic send_random_pairs(input int n);
    int sent;
    int dims;
    sent = 0;
    while (sent < n) begin
      dims = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      for (int i = 0; i < dims; i++) send_dim(rand_dim(), i == dims - 1);
      sent += dims;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest expected distance
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected distance, expected none, actual %0d", $time, m_tdata);
        err_count++;
      end else begin
        if (m_tdata !== OUT_DATA_BITS'(dist_q[0])) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, dist_q[0], m_tdata);
          err_count++;
        end
        void'(dist_q.pop_front());
      end
    end
  end

  // Extreme corners, overlap, touching, inverted boxes and short pairs
  task automatic test_directed();
    send_dim(mk_dim(C_MIN, C_MIN, C_MAX, C_MAX), 1'b1);
    send_dim(mk_dim(C_MAX, C_MAX, C_MIN, C_MIN), 1'b1);
    send_dim(mk_dim(-16'sd100, 16'sd100, -16'sd50, 16'sd50), 1'b1);
    send_dim(mk_dim(16'sd0, 16'sd256, 16'sd256, 16'sd512), 1'b1);
    send_dim(mk_dim(C_MAX, C_MIN, 16'sd0, 16'sd0), 1'b1);
    send_dim(mk_dim(16'sd100, -16'sd100, 16'sd50, -16'sd50), 1'b1);
    send_dim(mk_dim(16'sd0, 16'sd0, 16'sd768, 16'sd768), 1'b0);
    send_dim(mk_dim(16'sd0, 16'sd0, 16'sd1024, 16'sd1024), 1'b1);
    send_dim(mk_dim(16'sd0, 16'sd0, 16'sd1, 16'sd1), 1'b1);
    send_dim(mk_dim(16'sd0, 16'sd0, 16'sd0, 16'sd0), 1'b1);
    send_dim(mk_dim(-16'sd1, -16'sd1, -16'sd1, -16'sd1), 1'b1);
    wait_results_done();
  endtask

  // More dimensions than the core is sized for, all at the widest gap, then a short pair
  task automatic test_saturation();
    for (int i = 0; i < 17; i++) send_dim(mk_dim(C_MIN, C_MIN, C_MAX, C_MAX), i == 16);
    send_dim(mk_dim(16'sd0, 16'sd0, 16'sd1, 16'sd1), 1'b1);
    wait_results_done();
  endtask

  // Receiver holds off long enough that the core stalls its input
  task automatic test_backpressure();
    rx_hold_req = 400;
    for (int p = 0; p < 10; p++)
      for (int i = 0; i < 3; i++) send_dim(rand_dim(), i == 2);
    wait_results_done();
  endtask

  task automatic test_random_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random_pairs(520);
    wait_results_done();
  endtask

  task automatic test_random_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_pairs(120);
    wait_results_done();
  endtask

  // Main sequence
  initial begin
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    sum_sq_acc  = '0;
    err_count   = 0;
    rx_hold_req = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_saturation();
    test_backpressure();
    test_random_idle();
    test_random_full_rate();

    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("** box_min_distance_core: PASSED **");
    end else begin
      $display("** box_min_distance_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(3_000_000);
    $display("%0t: timeout", $time);
    $display("** box_min_distance_core: FAILED **");
    $finish;
  end

endmodule
